// ===== design/bvm_pkg.sv =====
// Shared types, register indexes and voxel constants for the binary volume morphology block.
`default_nettype none

package bvm_pkg;

   localparam int DEF_MAX_X      = 32;
   localparam int DEF_MAX_Y      = 32;
   localparam int DEF_MAX_Z      = 32;
   localparam int DEF_MAX_RADIUS = 3;

   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 6;

   localparam logic [CSR_IDX_W-1:0] REG_MODE   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_RADIUS = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_SIZE_X = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_SIZE_Y = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_SIZE_Z = 3'd4;

   localparam logic       MODE_DILATE  = 1'b0;
   localparam logic [1:0] RADIUS_RESET = 2'd1;
   localparam logic [5:0] SIZE_RESET   = 6'd32;

   localparam logic CMD_LOAD = 1'b0;
   localparam logic CMD_READ = 1'b1;

   localparam logic [7:0] VOX_SET   = 8'hFF;
   localparam logic [7:0] VOX_CLEAR = 8'h00;

   typedef struct packed {
      logic       command;
      logic [7:0] voxel_in;
   } req_type;

   typedef struct packed {
      logic [7:0] voxel_out;
      logic       last;
   } rsp_type;

endpackage

`default_nettype wire

// ===== design/bvm_div.sv =====
// Restoring divider, one quotient bit per cycle, used to split a raster index into coordinates.
`default_nettype none

module bvm_div #(
   parameter int NUM_W = 15,
   parameter int DEN_W = 6
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   input  wire logic [NUM_W-1:0] num,
   input  wire logic [DEN_W-1:0] den,
   output logic                  done,
   output logic      [NUM_W-1:0] quo,
   output logic      [DEN_W-1:0] rem
);

   localparam int CNT_W = $clog2(NUM_W + 1);

   logic             active_ff, active_in;
   logic             done_ff, done_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [NUM_W-1:0] quo_ff, quo_in;
   logic [DEN_W-1:0] rem_ff, rem_in;
   logic [DEN_W-1:0] den_ff, den_in;
   logic [DEN_W:0]   trial;
   logic [DEN_W:0]   diff;
   logic             fits;

   assign trial = {rem_ff, quo_ff[NUM_W-1]};
   assign diff  = trial - {1'b0, den_ff};
   assign fits  = trial >= {1'b0, den_ff};

   always_comb begin
      active_in = active_ff;
      done_in   = 1'b0;
      cnt_in    = cnt_ff;
      quo_in    = quo_ff;
      rem_in    = rem_ff;
      den_in    = den_ff;
      if (start) begin
         active_in = 1'b1;
         cnt_in    = CNT_W'(NUM_W);
         quo_in    = num;
         rem_in    = '0;
         den_in    = den;
      end else if (active_ff) begin
         rem_in = fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
         quo_in = (quo_ff << 1) | NUM_W'(fits);
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            active_in = 1'b0;
            done_in   = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         done_ff   <= 1'b0;
         cnt_ff    <= '0;
      end else begin
         active_ff <= active_in;
         done_ff   <= done_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign done = done_ff;
   assign quo  = quo_ff;
   assign rem  = rem_ff;

endmodule

`default_nettype wire

// ===== design/bvm_store.sv =====
// Single-port voxel memory with registered read data.
`default_nettype none

module bvm_store #(
   parameter int DEPTH = 32768,
   parameter int AW    = 15
) (
   input  wire logic          clock,
   input  wire logic          we,
   input  wire logic          re,
   input  wire logic [AW-1:0] addr,
   input  wire logic [7:0]    wdata,
   output logic      [7:0]    rdata
);

   logic [7:0] mem [DEPTH];
   logic [7:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[addr];
      end
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

// ===== design/bvm_seq.sv =====
// Read sequencer: splits the raster index, walks the cube one voxel per cycle, folds the result.
`default_nettype none

module bvm_seq #(
   parameter int MAX_X      = bvm_pkg::DEF_MAX_X,
   parameter int MAX_Y      = bvm_pkg::DEF_MAX_Y,
   parameter int MAX_Z      = bvm_pkg::DEF_MAX_Z,
   parameter int MAX_RADIUS = bvm_pkg::DEF_MAX_RADIUS
) (
   clock, reset, start, start_pos, start_last, erode, radius, sx, sy, sz, sxy,
   busy, mem_re, mem_addr, mem_rdata, res_valid, res_ready, res
);

   localparam int DEPTH = MAX_X * MAX_Y * MAX_Z;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int MAXXY = (MAX_X > MAX_Y) ? MAX_X : MAX_Y;
   localparam int MAXD  = (MAXXY > MAX_Z) ? MAXXY : MAX_Z;
   localparam int CW    = $clog2(MAXD + 1);
   localparam int RW    = $clog2(MAX_RADIUS + 1);
   localparam int NW    = ((CW > RW) ? CW : RW) + 2;

   input  wire logic            clock;
   input  wire logic            reset;
   input  wire logic            start;
   input  wire logic [AW-1:0]   start_pos;
   input  wire logic            start_last;
   input  wire logic            erode;
   input  wire logic [RW-1:0]   radius;
   input  wire logic [CW-1:0]   sx;
   input  wire logic [CW-1:0]   sy;
   input  wire logic [CW-1:0]   sz;
   input  wire logic [AW-1:0]   sxy;
   output logic                 busy;
   output logic                 mem_re;
   output logic      [AW-1:0]   mem_addr;
   input  wire logic [7:0]      mem_rdata;
   output logic                 res_valid;
   input  wire logic            res_ready;
   output bvm_pkg::rsp_type     res;

   typedef enum logic [2:0] {
      S_IDLE,
      S_DIV_X,
      S_DIV_Y,
      S_BASE,
      S_SCAN,
      S_LAST,
      S_DONE
   } state_type;

   state_type state_ff, state_in;

   logic [AW-1:0]          pos_ff, pos_in;
   logic                   last_ff, last_in;
   logic                   erode_ff, erode_in;
   logic [RW-1:0]          r_ff, r_in;
   logic [RW-1:0]          cnt_ff, cnt_in;
   logic [AW-1:0]          stride_ff, stride_in;
   logic [CW-1:0]          x_ff, x_in;
   logic [CW-1:0]          y_ff, y_in;
   logic [CW-1:0]          z_ff, z_in;
   logic [AW-1:0]          plane_ff, plane_in;
   logic [AW-1:0]          row_ff, row_in;
   logic [AW-1:0]          addr_ff, addr_in;
   logic signed [NW-1:0]   nx_ff, nx_in;
   logic signed [NW-1:0]   ny_ff, ny_in;
   logic signed [NW-1:0]   nz_ff, nz_in;
   logic signed [NW-1:0]   xlo_ff, xlo_in;
   logic signed [NW-1:0]   ylo_ff, ylo_in;
   logic signed [NW-1:0]   xhi_ff, xhi_in;
   logic signed [NW-1:0]   yhi_ff, yhi_in;
   logic signed [NW-1:0]   zhi_ff, zhi_in;
   logic                   pend_rd_ff, pend_rd_in;
   logic                   pend_out_ff, pend_out_in;
   logic                   hit_ff, hit_in;

   logic                   div_start;
   logic [AW-1:0]          div_num;
   logic [CW-1:0]          div_den;
   logic                   div_done;
   logic [AW-1:0]          div_quo;
   logic [CW-1:0]          div_rem;

   logic signed [NW-1:0]   xs, ys, zs, rs;
   logic signed [NW-1:0]   sxs, sys, szs;
   logic                   in_vol;
   logic                   bad;

   bvm_div #(
      .NUM_W (AW),
      .DEN_W (CW)
   ) u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (div_den),
      .done  (div_done),
      .quo   (div_quo),
      .rem   (div_rem)
   );

   assign xs  = $signed(NW'(x_ff));
   assign ys  = $signed(NW'(y_ff));
   assign zs  = $signed(NW'(z_ff));
   assign rs  = $signed(NW'(r_ff));
   assign sxs = $signed(NW'(sx));
   assign sys = $signed(NW'(sy));
   assign szs = $signed(NW'(sz));

   assign in_vol = (nx_ff >= 0) && (ny_ff >= 0) && (nz_ff >= 0) &&
                   (nx_ff < sxs) && (ny_ff < sys) && (nz_ff < szs);

   assign bad = erode_ff ? (pend_out_ff || (pend_rd_ff && (mem_rdata != bvm_pkg::VOX_SET)))
                         : (pend_rd_ff && (mem_rdata != bvm_pkg::VOX_CLEAR));

   assign div_start = ((state_ff == S_IDLE) && start) || ((state_ff == S_DIV_X) && div_done);
   assign div_num   = (state_ff == S_IDLE) ? start_pos : div_quo;
   assign div_den   = (state_ff == S_IDLE) ? sx : sy;

   always_comb begin
      state_in    = state_ff;
      pos_in      = pos_ff;
      last_in     = last_ff;
      erode_in    = erode_ff;
      r_in        = r_ff;
      cnt_in      = cnt_ff;
      stride_in   = stride_ff;
      x_in        = x_ff;
      y_in        = y_ff;
      z_in        = z_ff;
      plane_in    = plane_ff;
      row_in      = row_ff;
      addr_in     = addr_ff;
      nx_in       = nx_ff;
      ny_in       = ny_ff;
      nz_in       = nz_ff;
      xlo_in      = xlo_ff;
      ylo_in      = ylo_ff;
      xhi_in      = xhi_ff;
      yhi_in      = yhi_ff;
      zhi_in      = zhi_ff;
      pend_rd_in  = 1'b0;
      pend_out_in = 1'b0;
      hit_in      = hit_ff | bad;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               pos_in    = start_pos;
               last_in   = start_last;
               erode_in  = erode;
               r_in      = radius;
               stride_in = sxy + AW'(sx) + AW'(1);
               hit_in    = 1'b0;
               state_in  = S_DIV_X;
            end
         end
         S_DIV_X: begin
            if (div_done) begin
               x_in     = div_rem;
               state_in = S_DIV_Y;
            end
         end
         S_DIV_Y: begin
            if (div_done) begin
               y_in     = div_rem;
               z_in     = div_quo[CW-1:0];
               plane_in = pos_ff;
               cnt_in   = r_ff;
               state_in = S_BASE;
            end
         end
         S_BASE: begin
            if (cnt_ff == '0) begin
               row_in   = plane_ff;
               addr_in  = plane_ff;
               xlo_in   = xs - rs;
               ylo_in   = ys - rs;
               nx_in    = xs - rs;
               ny_in    = ys - rs;
               nz_in    = zs - rs;
               xhi_in   = xs + rs;
               yhi_in   = ys + rs;
               zhi_in   = zs + rs;
               state_in = S_SCAN;
            end else begin
               plane_in = plane_ff - stride_ff;
               cnt_in   = cnt_ff - RW'(1);
            end
         end
         S_SCAN: begin
            pend_rd_in  = in_vol;
            pend_out_in = !in_vol;
            if (nx_ff != xhi_ff) begin
               nx_in   = nx_ff + NW'(1);
               addr_in = addr_ff + AW'(1);
            end else if (ny_ff != yhi_ff) begin
               nx_in   = xlo_ff;
               ny_in   = ny_ff + NW'(1);
               row_in  = row_ff + AW'(sx);
               addr_in = row_ff + AW'(sx);
            end else if (nz_ff != zhi_ff) begin
               nx_in    = xlo_ff;
               ny_in    = ylo_ff;
               nz_in    = nz_ff + NW'(1);
               plane_in = plane_ff + sxy;
               row_in   = plane_ff + sxy;
               addr_in  = plane_ff + sxy;
            end else begin
               state_in = S_LAST;
            end
         end
         S_LAST: begin
            state_in = S_DONE;
         end
         S_DONE: begin
            if (res_ready) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_IDLE;
         pend_rd_ff  <= 1'b0;
         pend_out_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         pend_rd_ff  <= pend_rd_in;
         pend_out_ff <= pend_out_in;
      end
      pos_ff    <= pos_in;
      last_ff   <= last_in;
      erode_ff  <= erode_in;
      r_ff      <= r_in;
      cnt_ff    <= cnt_in;
      stride_ff <= stride_in;
      x_ff      <= x_in;
      y_ff      <= y_in;
      z_ff      <= z_in;
      plane_ff  <= plane_in;
      row_ff    <= row_in;
      addr_ff   <= addr_in;
      nx_ff     <= nx_in;
      ny_ff     <= ny_in;
      nz_ff     <= nz_in;
      xlo_ff    <= xlo_in;
      ylo_ff    <= ylo_in;
      xhi_ff    <= xhi_in;
      yhi_ff    <= yhi_in;
      zhi_ff    <= zhi_in;
      hit_ff    <= hit_in;
   end

   assign busy      = state_ff != S_IDLE;
   assign mem_re    = (state_ff == S_SCAN) && in_vol;
   assign mem_addr  = addr_ff;
   assign res_valid = state_ff == S_DONE;

   always_comb begin
      res.last = last_ff;
      if (erode_ff) begin
         res.voxel_out = hit_ff ? bvm_pkg::VOX_CLEAR : bvm_pkg::VOX_SET;
      end else begin
         res.voxel_out = hit_ff ? bvm_pkg::VOX_SET : bvm_pkg::VOX_CLEAR;
      end
   end

endmodule

`default_nettype wire

// ===== design/binary_volume_morphology_core.sv =====
// Binary 3D dilation / erosion over a cubic element: control registers, load path, output stage.
//
// Usage. Items arrive on req_* (valid/stall); each carries a command and a voxel byte.
// A load item stores the byte at the next raster position (x fastest, then y, then z);
// it produces nothing, and loads go back to back while req_stall is low. A read item
// yields one rsp_* item with the dilated or eroded voxel (0 or 255) of the next raster
// position; last marks the final voxel of the volume, after which the read position
// restarts at zero. A read runs the bit-serial divider that splits the raster index
// twice, then visits each cube position once, reading the single-port voxel memory
// at the positions inside the volume. req_stall stays high during a read. Registers
// are written on csr_* (valid/ready, always ready); each write holds req_stall high
// while the volume extent products settle. Reset (synchronous, active high) restores
// the register defaults and both raster positions; memory contents are kept and must
// be read only after being loaded, a rule the user keeps, unchecked by the block.
// A finished result sits in the output register until rsp_stall drops; items are still
// taken meanwhile, and a further finished read holds req_stall high until it drains.
`default_nettype none

module binary_volume_morphology_core #(
   parameter int MAX_X      = bvm_pkg::DEF_MAX_X,
   parameter int MAX_Y      = bvm_pkg::DEF_MAX_Y,
   parameter int MAX_Z      = bvm_pkg::DEF_MAX_Z,
   parameter int MAX_RADIUS = bvm_pkg::DEF_MAX_RADIUS
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_valid,
   output logic                                 req_stall,
   input  wire bvm_pkg::req_type                req_data,
   output logic                                 rsp_valid,
   input  wire logic                            rsp_stall,
   output bvm_pkg::rsp_type                     rsp_data,
   input  wire logic                            csr_valid,
   output logic                                 csr_ready,
   input  wire logic [bvm_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire logic [bvm_pkg::CSR_DATA_W-1:0]  csr_data
);

   localparam int DEPTH = MAX_X * MAX_Y * MAX_Z;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int TW    = $clog2(DEPTH + 1);
   localparam int SXYW  = $clog2(MAX_X * MAX_Y + 1);
   localparam int MAXXY = (MAX_X > MAX_Y) ? MAX_X : MAX_Y;
   localparam int MAXD  = (MAXXY > MAX_Z) ? MAXXY : MAX_Z;
   localparam int CW    = $clog2(MAXD + 1);
   localparam int RW    = $clog2(MAX_RADIUS + 1);

   logic            mode_ff;
   logic [1:0]      radius_ff;
   logic [5:0]      size_x_ff;
   logic [5:0]      size_y_ff;
   logic [5:0]      size_z_ff;
   logic [1:0]      settle_ff;
   logic [SXYW-1:0] sxy_ff;
   logic [TW-1:0]   total_ff;
   logic [AW-1:0]   load_index_ff, load_index_in;
   logic [AW-1:0]   read_index_ff, read_index_in;
   logic            rsp_valid_ff;
   bvm_pkg::rsp_type rsp_data_ff;

   logic [CW-1:0]   sx, sy, sz;
   logic [RW-1:0]   r;
   logic            csr_write;
   logic            req_accept;
   logic            load_accept;
   logic            read_accept;
   logic [AW-1:0]   load_pos;
   logic [AW-1:0]   read_pos;
   logic [TW-1:0]   load_next;
   logic [TW-1:0]   read_next;
   logic            read_last;
   logic            eng_busy;
   logic            eng_re;
   logic [AW-1:0]   eng_addr;
   logic            eng_valid;
   logic            eng_ready;
   bvm_pkg::rsp_type eng_res;
   logic [7:0]      mem_rdata;

   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;

   always_comb begin
      if (size_x_ff == '0) begin
         sx = CW'(1);
      end else if (32'(size_x_ff) > MAX_X) begin
         sx = CW'(MAX_X);
      end else begin
         sx = CW'(size_x_ff);
      end
      if (size_y_ff == '0) begin
         sy = CW'(1);
      end else if (32'(size_y_ff) > MAX_Y) begin
         sy = CW'(MAX_Y);
      end else begin
         sy = CW'(size_y_ff);
      end
      if (size_z_ff == '0) begin
         sz = CW'(1);
      end else if (32'(size_z_ff) > MAX_Z) begin
         sz = CW'(MAX_Z);
      end else begin
         sz = CW'(size_z_ff);
      end
      if (32'(radius_ff) > MAX_RADIUS) begin
         r = RW'(MAX_RADIUS);
      end else begin
         r = RW'(radius_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= bvm_pkg::MODE_DILATE;
         radius_ff <= bvm_pkg::RADIUS_RESET;
         size_x_ff <= bvm_pkg::SIZE_RESET;
         size_y_ff <= bvm_pkg::SIZE_RESET;
         size_z_ff <= bvm_pkg::SIZE_RESET;
         settle_ff <= 2'd2;
      end else begin
         if (csr_write) begin
            settle_ff <= 2'd2;
            case (csr_index)
               bvm_pkg::REG_MODE:   mode_ff   <= csr_data[0];
               bvm_pkg::REG_RADIUS: radius_ff <= csr_data[1:0];
               bvm_pkg::REG_SIZE_X: size_x_ff <= csr_data;
               bvm_pkg::REG_SIZE_Y: size_y_ff <= csr_data;
               bvm_pkg::REG_SIZE_Z: size_z_ff <= csr_data;
               default: begin
               end
            endcase
         end else if (settle_ff != 2'd0) begin
            settle_ff <= settle_ff - 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      sxy_ff   <= SXYW'(sx) * SXYW'(sy);
      total_ff <= TW'(sxy_ff) * TW'(sz);
   end

   assign req_stall   = eng_busy || (settle_ff != 2'd0);
   assign req_accept  = req_valid && !req_stall;
   assign load_accept = req_accept && (req_data.command == bvm_pkg::CMD_LOAD);
   assign read_accept = req_accept && (req_data.command == bvm_pkg::CMD_READ);

   assign load_pos  = (TW'(load_index_ff) >= total_ff) ? '0 : load_index_ff;
   assign load_next = TW'(load_pos) + TW'(1);
   assign load_index_in = (load_next >= total_ff) ? '0 : AW'(load_next);

   assign read_pos  = (TW'(read_index_ff) >= total_ff) ? '0 : read_index_ff;
   assign read_next = TW'(read_pos) + TW'(1);
   assign read_last = read_next == total_ff;
   assign read_index_in = read_last ? '0 : AW'(read_next);

   always_ff @(posedge clock) begin
      if (reset) begin
         load_index_ff <= '0;
         read_index_ff <= '0;
      end else begin
         if (load_accept) begin
            load_index_ff <= load_index_in;
         end
         if (read_accept) begin
            read_index_ff <= read_index_in;
         end
      end
   end

   bvm_seq #(
      .MAX_X      (MAX_X),
      .MAX_Y      (MAX_Y),
      .MAX_Z      (MAX_Z),
      .MAX_RADIUS (MAX_RADIUS)
   ) u_seq (
      .clock      (clock),
      .reset      (reset),
      .start      (read_accept),
      .start_pos  (read_pos),
      .start_last (read_last),
      .erode      (mode_ff),
      .radius     (r),
      .sx         (sx),
      .sy         (sy),
      .sz         (sz),
      .sxy        (AW'(sxy_ff)),
      .busy       (eng_busy),
      .mem_re     (eng_re),
      .mem_addr   (eng_addr),
      .mem_rdata  (mem_rdata),
      .res_valid  (eng_valid),
      .res_ready  (eng_ready),
      .res        (eng_res)
   );

   bvm_store #(
      .DEPTH (DEPTH),
      .AW    (AW)
   ) u_store (
      .clock (clock),
      .we    (load_accept),
      .re    (eng_re),
      .addr  (eng_busy ? eng_addr : load_pos),
      .wdata (req_data.voxel_in),
      .rdata (mem_rdata)
   );

   assign eng_ready = !rsp_valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (eng_ready) begin
         rsp_valid_ff <= eng_valid;
      end
      if (eng_ready && eng_valid) begin
         rsp_data_ff <= eng_res;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire
